FILE: src/gha_pkg.sv
package gha_pkg;

	localparam int IDX_W = 10;
	localparam int GEN_W = 32;
	localparam int CNT_W = 11;

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_CHECK   = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_ALIVE = 2'd2,
		STATUS_RSVD      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] slot_index;
		logic [GEN_W-1:0] slot_generation;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] handle_index;
		logic [GEN_W-1:0] handle_generation;
		logic             is_live;
		logic [1:0]       status;
		logic [CNT_W-1:0] live_count;
	} rsp_t;

endpackage

FILE: src/gha_if.sv
interface gha_req_if;
	import gha_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gha_rsp_if;
	import gha_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/generational_handle_allocator_top.sv
// Path from input accept to the result: a create of a never-used slot, a full create or a
// handle past the used mark goes straight to the output register; destroy and check first
// read the slot entry; a create from the free stack reads the free stack, then the slot entry.
// A new request is taken only when idle, after the last result is loaded for output, later while held off.
// Reset clears the counters, the state and the output valid flag only; slots at or above the
// used mark read as dead, so the slot memory needs no clearing pass.
module generational_handle_allocator_top #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	gha_req_if.sink       req,
	gha_rsp_if.source     rsp
);
	import gha_pkg::*;

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int EW = GEN_W + 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SLOTS);

	state_t state_q, state_d;

	logic [CW-1:0] depth_q, mark_q, live_q;
	logic [1:0]       cmd_q;
	logic [GEN_W-1:0] gen_q;
	logic [AW-1:0]    slot_q;
	rsp_t             res_q;
	rsp_t             out_q;
	logic             out_valid_q;

	rsp_t             acc_res;
	rsp_t             rd_res;
	rsp_t             out_res;

	logic          ent_we;
	logic [AW-1:0] ent_waddr, ent_raddr;
	logic [EW-1:0] ent_wdata, ent_rdata;
	logic          fs_we;
	logic [AW-1:0] fs_waddr, fs_raddr;
	logic [AW-1:0] fs_wdata, fs_rdata;

	logic accept;
	logic idx_used;
	logic rd_live;
	logic out_load;

	gha_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	gha_ram #(.WIDTH(AW), .DEPTH(MAX_SLOTS)) u_free_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign idx_used  = 32'(req.data.slot_index) < 32'(mark_q);
	assign rd_live   = ent_rdata[GEN_W] && (ent_rdata[GEN_W-1:0] == gen_q);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		state_d   = state_q;
		ent_we    = 1'b0;
		ent_waddr = slot_q;
		ent_wdata = '0;
		ent_raddr = '0;
		fs_we     = 1'b0;
		fs_waddr  = AW'(depth_q);
		fs_wdata  = slot_q;
		fs_raddr  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_OUT;
					if (req.data.cmd == CMD_CREATE) begin
						if (depth_q != '0) begin
							fs_raddr = AW'(depth_q - CW'(1));
							state_d  = ST_POP;
						end else if (mark_q < MAX_CNT) begin
							ent_we    = 1'b1;
							ent_waddr = AW'(mark_q);
							ent_wdata = {1'b1, {GEN_W{1'b0}}};
						end
					end else if (idx_used) begin
						ent_raddr = AW'(req.data.slot_index);
						state_d   = ST_RD;
					end
				end
			end
			ST_POP: begin
				ent_raddr = fs_rdata;
				state_d   = ST_RD;
			end
			ST_RD: begin
				state_d = ST_OUT;
				if (cmd_q == CMD_CREATE) begin
					ent_we    = 1'b1;
					ent_wdata = {1'b1, ent_rdata[GEN_W-1:0]};
				end else if (cmd_q == CMD_DESTROY && rd_live) begin
					ent_we    = 1'b1;
					ent_wdata = {1'b0, ent_rdata[GEN_W-1:0] + GEN_W'(1)};
					fs_we     = depth_q < MAX_CNT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		acc_res.handle_index      = req.data.slot_index;
		acc_res.handle_generation = req.data.slot_generation;
		acc_res.is_live           = 1'b0;
		acc_res.status            = STATUS_OK;
		acc_res.live_count        = '0;
		if (req.data.cmd == CMD_DESTROY) begin
			acc_res.status = STATUS_NOT_ALIVE;
		end else if (req.data.cmd == CMD_CREATE && depth_q == '0) begin
			if (mark_q < MAX_CNT) begin
				acc_res.handle_index      = IDX_W'(mark_q);
				acc_res.handle_generation = '0;
			end else begin
				acc_res.handle_index      = '0;
				acc_res.handle_generation = '0;
				acc_res.status            = STATUS_FULL;
			end
		end

		rd_res = res_q;
		if (cmd_q == CMD_CREATE) begin
			rd_res.handle_index      = IDX_W'(slot_q);
			rd_res.handle_generation = ent_rdata[GEN_W-1:0];
			rd_res.status            = STATUS_OK;
		end else begin
			rd_res.is_live = rd_live;
			if (cmd_q == CMD_DESTROY && !rd_live) begin
				rd_res.status = STATUS_NOT_ALIVE;
			end else begin
				rd_res.status = STATUS_OK;
			end
		end

		out_res            = res_q;
		out_res.live_count = CNT_W'(live_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			mark_q      <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && req.data.cmd == CMD_CREATE) begin
				if (depth_q != '0) begin
					depth_q <= depth_q - CW'(1);
				end else if (mark_q < MAX_CNT) begin
					mark_q <= mark_q + CW'(1);
					live_q <= live_q + CW'(1);
				end
			end
			if (state_q == ST_RD) begin
				if (cmd_q == CMD_CREATE) begin
					live_q <= live_q + CW'(1);
				end else if (cmd_q == CMD_DESTROY && rd_live) begin
					if (fs_we) begin
						depth_q <= depth_q + CW'(1);
					end
					if (live_q != '0) begin
						live_q <= live_q - CW'(1);
					end
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.data.cmd;
			gen_q  <= req.data.slot_generation;
			slot_q <= AW'(req.data.slot_index);
			res_q  <= acc_res;
		end else if (state_q == ST_POP) begin
			slot_q <= fs_rdata;
		end else if (state_q == ST_RD) begin
			res_q <= rd_res;
		end
		if (out_load) begin
			out_q <= out_res;
		end
	end

endmodule

FILE: src/gha_ram.sv
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
